@@ rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg: shared constants and types for the chained hash table
// Table geometry, field widths, operation codes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

  // table geometry
  localparam int NUM_BUCKETS  = 1021;
  localparam int BUCKET_DEPTH = 8;
  localparam int KEY_BITS     = 32;
  localparam int VALUE_BITS   = 32;

  // result field widths
  localparam int BUCKET_W = 10;
  localparam int CMP_W    = 4;

  // derived widths
  localparam int FILL_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W    = $clog2(BUCKET_DEPTH);
  localparam int ENTRIES  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ENTRY_AW = $clog2(ENTRIES);

  // stream payload widths
  localparam int IN_DATA_W  = KEY_BITS + VALUE_BITS;
  localparam int OUT_DATA_W = 1 + 32 + BUCKET_W + CMP_W + 1;

  // modulo by folding: 2^FOLD_SHIFT is congruent to FOLD_MULT mod NUM_BUCKETS
  localparam int FOLD_SHIFT = 10;
  localparam int FOLD_MULT  = (1 << FOLD_SHIFT) % NUM_BUCKETS;
  localparam int HASH_FOLDS = 4;
  localparam int FOLD_CW    = $clog2(HASH_FOLDS);

  // operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture accepted word
    logic fold;        // one hash fold step
    logic set_bucket;  // final reduce into bucket index
    logic clr;         // clear one fill counter
    logic ins;         // perform insert (or flag overflow)
    logic rd_step;     // issue entry read, advance index
    logic cmp_en;      // compare returned entry
    logic emit;        // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;   // clearing the last fill counter
    logic fill_zero;  // bucket empty
    logic is_search;  // captured op is a search
    logic cmp_valid;  // entry read data valid
    logic match;      // entry key equals target
    logic last_cmp;   // this compare reaches the fill count
    logic out_free;   // output register can take a word
  } stat_t;

endpackage

@@ rtl/chained_hash_table_lookup_top.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_lookup_top: hash table with separate chaining
// Insert appends (key, value) to bucket key mod 1021; search walks the
// bucket oldest first and reports the first match.
// ----------------------------------------------------------------------------
//
// channel | dir | bits                | word contents (low bit up)
// --------+-----+---------------------+------------------------------------
// in_     | in  | tdata 64, tuser 1   | tdata: key[31:0], value_in[63:32]
//         |     |                     | tuser: mode (0 insert, 1 search)
// out_    | out | tdata 48            | found, value_out, bucket, compares,
//         |     |                     | overflow
//
// Sequence: an accepted word passes four fold steps of the modulo unit, the
//   final reduce to a bucket index and the registered fill counter read; an
//   insert then updates the bucket, a search makes one entry memory read per
//   compare until a match or the bucket's fill count (none if it is empty).
// Reset: rst_n synchronous, active low. After reset a clearing pass zeroes
//   the 1021 fill counters, one per cycle; no word is accepted meanwhile.
// Stalls: one item at a time. A finished result sits in the output register
//   while the next word is accepted and processed; it is delivered only once
//   the earlier one has been taken.
//
module chained_hash_table_lookup_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cht_pkg::IN_DATA_W-1:0]     in_tdata,   // key[31:0], value_in[63:32]
  input  logic [0:0]                        in_tuser,   // mode[0]
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cht_pkg::OUT_DATA_W-1:0]    out_tdata   // found[0], value_out[32:1],
                                                        // bucket[42:33], compares[46:43],
                                                        // overflow[47]
);

  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t st;

  // sequencer: clearing pass, hashing, lookup, result hand-off
  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: modulo, fill counters, entry memories, output register
  cht_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

@@ rtl/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// cht_ctrl: chained hash table sequencer
// One-hot state machine: fill counter clearing after reset, hashing,
// fill lookup, insert or bucket walk, result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cht_pkg::stat_t st,
  output cht_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_HASH    = 8'b0000_0100,
    S_BUCKET  = 8'b0000_1000,
    S_FILL_RD = 8'b0001_0000,
    S_FILL    = 8'b0010_0000,
    S_SEARCH  = 8'b0100_0000,
    S_RESULT  = 8'b1000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [cht_pkg::FOLD_CW-1:0]   fold_cnt_r, fold_cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    fold_cnt_nxt = fold_cnt_r;
    cmd          = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load     = 1'b1;
          fold_cnt_nxt = '0;
          state_nxt    = S_HASH;
        end
      end
      S_HASH: begin
        cmd.fold     = 1'b1;
        fold_cnt_nxt = fold_cnt_r + 1'b1;
        if (fold_cnt_r == cht_pkg::FOLD_CW'(cht_pkg::HASH_FOLDS - 1)) state_nxt = S_BUCKET;
      end
      S_BUCKET: begin
        cmd.set_bucket = 1'b1;
        state_nxt      = S_FILL_RD;
      end
      S_FILL_RD: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (!st.is_search) begin
          cmd.ins   = 1'b1;
          state_nxt = S_RESULT;
        end else if (st.fill_zero) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.rd_step = 1'b1;
        cmd.cmp_en  = 1'b1;
        if (st.cmp_valid && (st.match || st.last_cmp)) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      fold_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      fold_cnt_r <= fold_cnt_nxt;
    end
  end

  // a search leaves the walk only on a compare
  a_search_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && !st.cmp_valid) |=> (state_r == S_SEARCH))
    else $error("search ended without a compare");

  // a finished result is handed off as soon as the output slot frees
  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && st.out_free) |=> (state_r == S_IDLE))
    else $error("result not handed off");

endmodule

@@ rtl/cht_dpath.sv @@
// ----------------------------------------------------------------------------
// cht_dpath: chained hash table datapath
// Fold-based modulo, fill counter memory, key/value entry memories,
// compare logic and the output register.
// ----------------------------------------------------------------------------
module cht_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [cht_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cht_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  cht_pkg::cmd_t                    cmd,
  output cht_pkg::stat_t                   st
);

  // captured word
  logic                              mode_r;
  logic [cht_pkg::KEY_BITS-1:0]      key_r;
  logic [cht_pkg::VALUE_BITS-1:0]    val_r;

  // hashing
  logic [cht_pkg::KEY_BITS-1:0]      hx_r, hx_nxt;
  logic [cht_pkg::BUCKET_W-1:0]      bucket_r, bucket_nxt;

  // fill counters
  logic [cht_pkg::FILL_W-1:0]        fill_mem [0:cht_pkg::NUM_BUCKETS-1];
  logic [cht_pkg::FILL_W-1:0]        fill_q;
  logic [cht_pkg::BUCKET_W-1:0]      clr_addr_r;
  logic                              fill_full;
  logic                              fill_we;
  logic [cht_pkg::BUCKET_W-1:0]      fill_waddr;
  logic [cht_pkg::FILL_W-1:0]        fill_wdata;

  // entries
  logic [cht_pkg::KEY_BITS-1:0]      key_mem [0:cht_pkg::ENTRIES-1];
  logic [cht_pkg::VALUE_BITS-1:0]    val_mem [0:cht_pkg::ENTRIES-1];
  logic [cht_pkg::KEY_BITS-1:0]      key_q;
  logic [cht_pkg::VALUE_BITS-1:0]    val_q;
  logic [cht_pkg::ENTRY_AW-1:0]      base_addr;
  logic [cht_pkg::ENTRY_AW-1:0]      rd_addr;
  logic [cht_pkg::ENTRY_AW-1:0]      wr_addr;
  logic [cht_pkg::IDX_W-1:0]         rd_idx_r;
  logic                              rdv_r;
  logic                              ent_we;

  // result
  logic                              found_r;
  logic [31:0]                       vout_r;
  logic [cht_pkg::FILL_W-1:0]        cmp_r;
  logic [cht_pkg::FILL_W-1:0]        cmp_inc;
  logic                              ovf_r;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [cht_pkg::OUT_DATA_W-1:0]    out_tdata_r;

  // x = hi*2^10 + lo  ==  hi*FOLD_MULT + lo  (mod NUM_BUCKETS)
  always_comb begin
    hx_nxt = cht_pkg::KEY_BITS'(hx_r >> cht_pkg::FOLD_SHIFT)
             * cht_pkg::KEY_BITS'(cht_pkg::FOLD_MULT)
             + cht_pkg::KEY_BITS'(hx_r[cht_pkg::FOLD_SHIFT-1:0]);
  end

  // after the folds the value is below twice the bucket count
  always_comb begin
    if (hx_r[cht_pkg::BUCKET_W:0] >= (cht_pkg::BUCKET_W+1)'(cht_pkg::NUM_BUCKETS)) begin
      bucket_nxt = cht_pkg::BUCKET_W'(hx_r[cht_pkg::BUCKET_W:0]
                   - (cht_pkg::BUCKET_W+1)'(cht_pkg::NUM_BUCKETS));
    end else begin
      bucket_nxt = hx_r[cht_pkg::BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser[0];
      key_r  <= in_tdata[cht_pkg::KEY_BITS-1:0];
      val_r  <= in_tdata[cht_pkg::IN_DATA_W-1:cht_pkg::KEY_BITS];
      hx_r   <= in_tdata[cht_pkg::KEY_BITS-1:0];
    end else if (cmd.fold) begin
      hx_r   <= hx_nxt;
    end
    if (cmd.set_bucket) bucket_r <= bucket_nxt;
  end

  // fill counter memory, one write port, registered read at bucket_r
  assign fill_full  = (fill_q >= cht_pkg::FILL_W'(cht_pkg::BUCKET_DEPTH));
  assign fill_we    = cmd.clr || (cmd.ins && !fill_full);
  assign fill_waddr = cmd.clr ? clr_addr_r : bucket_r;
  assign fill_wdata = cmd.clr ? '0 : fill_q + 1'b1;

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_q <= fill_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // entry memories
  assign base_addr = cht_pkg::ENTRY_AW'(bucket_r) * cht_pkg::ENTRY_AW'(cht_pkg::BUCKET_DEPTH);
  assign rd_addr   = base_addr + cht_pkg::ENTRY_AW'(rd_idx_r);
  assign wr_addr   = base_addr + cht_pkg::ENTRY_AW'(fill_q[cht_pkg::IDX_W-1:0]);
  assign ent_we    = cmd.ins && !fill_full;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[wr_addr] <= key_r;
      val_mem[wr_addr] <= val_r;
    end
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_step) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.rd_step;
    end
  end

  // compare and result collection
  assign cmp_inc = cmp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      cmp_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      cmp_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.cmp_en && rdv_r) begin
        cmp_r <= cmp_inc;
        if (key_q == key_r) found_r <= 1'b1;
      end
      if (cmd.ins && fill_full) ovf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vout_r <= '0;
    end else if (cmd.cmp_en && rdv_r && (key_q == key_r)) begin
      vout_r <= 32'(val_q);
    end
  end

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
    if (cmd.emit)                   out_tvalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_tdata_r <= {ovf_r, cht_pkg::CMP_W'(cmp_r), bucket_r, vout_r, found_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    st.clr_last  = (clr_addr_r == cht_pkg::BUCKET_W'(cht_pkg::NUM_BUCKETS - 1));
    st.fill_zero = (fill_q == '0);
    st.is_search = (mode_r == cht_pkg::MODE_SEARCH);
    st.cmp_valid = rdv_r;
    st.match     = (key_q == key_r);
    st.last_cmp  = (cmp_inc == fill_q);
    st.out_free  = !out_tvalid_r || out_tready;
  end

  // a hit always follows at least one compare
  a_found_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (cmp_r != '0))
    else $error("found without a compare");

  // overflow only on inserts
  a_ovf_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (mode_r == cht_pkg::MODE_INSERT))
    else $error("overflow flagged on a search");

  // a bucket walk never compares beyond the bucket depth
  a_cmp_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmp_en && rdv_r) |-> (cmp_r < cht_pkg::FILL_W'(cht_pkg::BUCKET_DEPTH)))
    else $error("compare beyond bucket depth");

endmodule

@@ verif/tb_chained_hash_table_lookup_top.sv @@
// ----------------------------------------------------------------------------
// tb_chained_hash_table_lookup_top: self-checking bench for the hash table
// Drives insert and search words into the stream input and mirrors the table
// (per-bucket entry lists and fill counts) to predict each result word.
// Directed words cover empty, hit, miss, duplicate and full-bucket cases;
// random words concentrate on a few hot buckets so chains fill and overflow.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HOT_COUNT  = 24;   // buckets the random words pile into
  localparam int         HOLD_TICKS = 400;  // long receiver hold-off
  localparam int         TAIL_TICKS = 40;   // settle time after the last result
  localparam bit [31:0]  HASH_MOD   = cht_pkg::NUM_BUCKETS;

  // expected result word, one per accepted input word
  typedef struct packed {
    logic                         found;
    logic [31:0]                  value;
    logic [cht_pkg::BUCKET_W-1:0] bucket;
    logic [cht_pkg::CMP_W-1:0]    compares;
    logic                         overflow;
  } lookup_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [cht_pkg::IN_DATA_W-1:0]   in_tdata = '0;   // key[31:0], value_in[63:32]
  logic [0:0]                      in_tuser = '0;   // mode[0]
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cht_pkg::OUT_DATA_W-1:0]  out_tdata;       // found[0], value_out[32:1],
                                                    // bucket[42:33], compares[46:43],
                                                    // overflow[47]

  // mirror of the table contents
  logic [31:0] mirror_key [cht_pkg::NUM_BUCKETS][cht_pkg::BUCKET_DEPTH];
  logic [31:0] mirror_val [cht_pkg::NUM_BUCKETS][cht_pkg::BUCKET_DEPTH];
  int          mirror_fill [cht_pkg::NUM_BUCKETS] = '{default: 0};
  logic [31:0] stored_keys[$];             // keys that made it into the table

  lookup_result_t pending_results[$];
  int             err_count = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_req = 1'b0;
  int             hold_left = 0;
  int             hot_bucket [HOT_COUNT];

  chained_hash_table_lookup_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table mirror: applies one accepted word and queues the result it causes.
  // Insert appends to the chain unless the chain is full; search walks the
  // chain oldest first and stops on the first key match.
  // --------------------------------------------------------------------------
  function automatic void predict_lookup(input logic mode, input logic [31:0] key,
                                         input logic [31:0] value);
    lookup_result_t res;
    int             b;
    int             n;
    res = '0;
    b = int'(key % HASH_MOD);
    res.bucket = cht_pkg::BUCKET_W'(b);
    if (mode == cht_pkg::MODE_INSERT) begin
      if (mirror_fill[b] >= cht_pkg::BUCKET_DEPTH) begin
        res.overflow = 1'b1;                // chain full, word dropped
      end else begin
        mirror_key[b][mirror_fill[b]] = key;
        mirror_val[b][mirror_fill[b]] = value;
        mirror_fill[b]++;
        stored_keys = {stored_keys, key};
      end
    end else begin
      for (n = 0; n < mirror_fill[b]; n++) begin
        res.compares++;
        if (mirror_key[b][n] == key) begin
          res.found = 1'b1;
          res.value = mirror_val[b][n];
          break;
        end
      end
    end
    pending_results = {pending_results, res};
  endfunction

  // compare one result word against the oldest expectation
  task automatic check_result(input logic [cht_pkg::OUT_DATA_W-1:0] word);
    lookup_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result word %0h", word);
      err_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (word[0] !== exp_res.found) begin
      $error("found: expected %0h, got %0h", exp_res.found, word[0]);
      err_count++;
    end
    if (word[32:1] !== exp_res.value) begin
      $error("value_out: expected %0h, got %0h", exp_res.value, word[32:1]);
      err_count++;
    end
    if (word[42:33] !== exp_res.bucket) begin
      $error("bucket: expected %0d, got %0d", exp_res.bucket, word[42:33]);
      err_count++;
    end
    if (word[46:43] !== exp_res.compares) begin
      $error("compares: expected %0d, got %0d", exp_res.compares, word[46:43]);
      err_count++;
    end
    if (word[47] !== exp_res.overflow) begin
      $error("overflow: expected %0h, got %0h", exp_res.overflow, word[47]);
      err_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check on every accepted word, then pick next cycle's tready.
  // A hold request from a test starts a long hold-off counted here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result(out_tdata);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_TICKS;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Input side: optional idle gap, then hold the word until accepted.
  // tvalid stays high between back-to-back words; the mirror is updated at
  // the accepting edge so expectations are in acceptance order.
  // --------------------------------------------------------------------------
  task automatic push_request(input logic mode, input logic [31:0] key,
                              input logic [31:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {value, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_lookup(mode, key, value);
  endtask

  // random key that lands in bucket b, spread over the whole key range
  function automatic logic [31:0] key_in_bucket(input int b);
    int unsigned span;
    span = (32'hFFFF_FFFF - b) / cht_pkg::NUM_BUCKETS;
    return b + cht_pkg::NUM_BUCKETS * $urandom_range(span, 0);
  endfunction

  function automatic logic [31:0] hot_key();
    return key_in_bucket(hot_bucket[$urandom_range(HOT_COUNT - 1, 0)]);
  endfunction

  // one random word: mostly inserts and searches in hot buckets, searches of
  // stored keys for hits, and a few fully random keys as noise
  task automatic push_random_word();
    int          pick;
    logic [31:0] key;
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      key = ($urandom_range(9, 0) == 0) ? $urandom() : hot_key();
      push_request(cht_pkg::MODE_INSERT, key, $urandom());
    end else if (pick < 75 && stored_keys.size() > 0) begin
      key = stored_keys[$urandom_range(stored_keys.size() - 1, 0)];
      push_request(cht_pkg::MODE_SEARCH, key, $urandom());
    end else if (pick < 90) begin
      push_request(cht_pkg::MODE_SEARCH, hot_key(), $urandom());
    end else begin
      push_request(cht_pkg::MODE_SEARCH, $urandom(), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // searches into an empty table: zero compares, nothing found
  task automatic test_empty_table();
    push_request(cht_pkg::MODE_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(cht_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // extreme keys and values, first and last bucket, hit and miss
  task automatic test_insert_search();
    push_request(cht_pkg::MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(cht_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_request(cht_pkg::MODE_INSERT, cht_pkg::NUM_BUCKETS - 1, 32'hA5A5_A5A5);
    push_request(cht_pkg::MODE_SEARCH, 32'h0000_0000, 32'h0000_0000);
    push_request(cht_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(cht_pkg::MODE_SEARCH, cht_pkg::NUM_BUCKETS - 1, 32'h0000_0000);
    // same bucket as key 0, not stored: one compare, miss
    push_request(cht_pkg::MODE_SEARCH, cht_pkg::NUM_BUCKETS, 32'h0000_0000);
  endtask

  // fill one chain to the top, overflow it, search first, last and missing
  task automatic test_full_bucket();
    int b;
    int i;
    b = 777;
    for (i = 0; i < cht_pkg::BUCKET_DEPTH; i++)
      push_request(cht_pkg::MODE_INSERT, b + cht_pkg::NUM_BUCKETS * (i * 500_000),
                   32'h1000 + i);
    push_request(cht_pkg::MODE_INSERT, b + cht_pkg::NUM_BUCKETS * 1_000_000,
                 32'hDEAD_BEEF);  // dropped
    push_request(cht_pkg::MODE_SEARCH, b, 32'h0);
    push_request(cht_pkg::MODE_SEARCH,
                 b + cht_pkg::NUM_BUCKETS * ((cht_pkg::BUCKET_DEPTH - 1) * 500_000), 32'h0);
    push_request(cht_pkg::MODE_SEARCH, b + cht_pkg::NUM_BUCKETS * 1_000_000,
                 32'h0);  // full walk, miss
  endtask

  // duplicate keys: the oldest entry wins
  task automatic test_duplicates();
    push_request(cht_pkg::MODE_INSERT, 32'd5, 32'h0000_0001);
    push_request(cht_pkg::MODE_INSERT, 32'd5, 32'h0000_0002);
    push_request(cht_pkg::MODE_SEARCH, 32'd5, 32'h0000_0000);
  endtask

  // random traffic with a fresh set of hot buckets
  task automatic test_random(input int count, input int tx_idle, input int rx_idle);
    int i;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (i = 0; i < HOT_COUNT; i++)
      hot_bucket[i] = $urandom_range(cht_pkg::NUM_BUCKETS - 1, 0);
    for (i = 0; i < count; i++)
      push_random_word();
  endtask

  // receiver stops for a long stretch while the sender keeps offering words
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (i = 0; i < 30; i++)
      push_random_word();
  endtask

  initial begin
    for (int i = 0; i < HOT_COUNT; i++)
      hot_bucket[i] = i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at full speed
    test_empty_table();
    test_insert_search();
    test_full_bucket();
    test_duplicates();

    test_random(610, 35, 74);
    test_random(610, 74, 35);
    test_backpressure();
    test_random(600, 0, 0);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_TICKS) @(posedge clk);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run, clearing pass included
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
